// ----- rtl/hsl2rgb_pkg.sv -----
// Package for the HSL to RGB24 pixel converter: fixed-point widths,
// pixel and inter-stage types, sector codes and the byte quantizer.
// Depends on nothing; every rtl file of the converter imports it.
package hsl2rgb_pkg;

    // Q0.FRAC_BITS fractions; field carries one extra bit so 1.0 fits
    localparam int FRAC_BITS  = 16;
    localparam int FIELD_BITS = FRAC_BITS + 1;
    localparam int WIDE_BITS  = 2 * FRAC_BITS;
    localparam int CW         = WIDE_BITS + 1;    // chroma, x and m width
    localparam int VW         = CW + 1;           // channel sum width
    localparam int QW         = VW + 8;           // 255 * channel width
    localparam int HPW        = FIELD_BITS + 3;   // 6 * hue width

    localparam logic [FIELD_BITS-1:0] ONE_Q = FIELD_BITS'(1) << FRAC_BITS;

    // Hue sectors, one per sixth of the color wheel
    typedef enum logic [2:0] {
        SECT_RY = 3'd0,
        SECT_YG = 3'd1,
        SECT_GC = 3'd2,
        SECT_CB = 3'd3,
        SECT_BM = 3'd4,
        SECT_MR = 3'd5
    } t_sector;

    typedef struct packed {
        logic [FIELD_BITS-1:0] hue;
        logic [FIELD_BITS-1:0] saturation;
        logic [FIELD_BITS-1:0] lightness;
    } t_hsl_pixel;

    typedef struct packed {
        logic [7:0] red_byte;
        logic [7:0] green_byte;
        logic [7:0] blue_byte;
    } t_rgb_pixel;

    // After the prep stage
    typedef struct packed {
        logic                  valid;
        logic                  hue_ok;
        t_sector               sector;
        logic [FIELD_BITS-1:0] span;
        logic [FIELD_BITS-1:0] sat;
        logic [FIELD_BITS-1:0] light;
        logic [FIELD_BITS-1:0] t_fac;
    } t_prep_stage;

    // After the x and m stage
    typedef struct packed {
        logic          valid;
        logic          hue_ok;
        t_sector       sector;
        logic [CW-1:0] chroma;
        logic [CW-1:0] x_val;
        logic [CW-1:0] m_val;
    } t_mix_stage;

    // round(255 * v) with v in Q.WIDE_BITS, saturated at 255
    function automatic logic [7:0] quantize(input logic [VW-1:0] v);
        logic [QW-1:0] prod;
        logic [QW-WIDE_BITS-1:0] whole;
        begin
            prod  = ({8'd0, v} << 8) - {8'd0, v} + (QW'(1) << (WIDE_BITS - 1));
            whole = prod[QW-1:WIDE_BITS];
            quantize = (whole > (QW-WIDE_BITS)'(255)) ? 8'hFF : whole[7:0];
        end
    endfunction

endpackage

// ----- rtl/hsl2rgb_prep.sv -----
// First pipeline stage: clamps S and L, forms the chroma span 2*min(L,1-L),
// the hue sector and the sector fraction factor. Uses hsl2rgb_pkg.
module hsl2rgb_prep (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  hsl2rgb_pkg::t_hsl_pixel i_pixel,
    output hsl2rgb_pkg::t_prep_stage o_stage
);
    import hsl2rgb_pkg::*;

    logic [FIELD_BITS-1:0] sat_c;
    logic [FIELD_BITS-1:0] light_c;
    logic [FIELD_BITS-1:0] light_inv;
    logic [FIELD_BITS-1:0] low_side;
    logic [HPW-1:0]        hp;
    logic [FIELD_BITS-1:0] frac;
    t_prep_stage           r_stage;
    t_prep_stage           n_stage;

    // Clamp, fold lightness, scale hue by six
    always_comb begin
        sat_c     = (i_pixel.saturation > ONE_Q) ? ONE_Q : i_pixel.saturation;
        light_c   = (i_pixel.lightness > ONE_Q) ? ONE_Q : i_pixel.lightness;
        light_inv = ONE_Q - light_c;
        low_side  = (light_c <= light_inv) ? light_c : light_inv;
        hp        = ({3'd0, i_pixel.hue} << 2) + ({3'd0, i_pixel.hue} << 1);
        frac      = {1'b0, hp[FRAC_BITS-1:0]};

        n_stage        = r_stage;
        n_stage.valid  = i_valid;
        if (i_valid) begin
            n_stage.hue_ok = (i_pixel.hue < ONE_Q);
            n_stage.sector = t_sector'(hp[FRAC_BITS+2:FRAC_BITS]);
            n_stage.span   = {low_side[FIELD_BITS-2:0], 1'b0};
            n_stage.sat    = sat_c;
            n_stage.light  = light_c;
            n_stage.t_fac  = hp[FRAC_BITS] ? (ONE_Q - frac) : frac;
        end
    end

    // Hold payload, clear valid on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ----- rtl/hsl2rgb_chroma.sv -----
// Second and third pipeline stages: chroma c = span * S, then
// x = floor(c * t) and m = L - c/2. Uses hsl2rgb_pkg.
module hsl2rgb_chroma (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  hsl2rgb_pkg::t_prep_stage i_stage,
    output hsl2rgb_pkg::t_mix_stage  o_stage
);
    import hsl2rgb_pkg::*;

    localparam int PW = CW + FIELD_BITS;

    logic                  r_c_valid;
    logic                  r_c_hue_ok;
    t_sector               r_c_sector;
    logic [CW-1:0]         r_c_chroma;
    logic [FIELD_BITS-1:0] r_c_light;
    logic [FIELD_BITS-1:0] r_c_t_fac;
    logic [CW-1:0]         n_c_chroma;
    logic [PW-1:0]         x_prod;
    t_mix_stage            r_stage;
    t_mix_stage            n_stage;

    // Chroma product, 17 x 17 bits
    assign n_c_chroma = CW'({{(CW-FIELD_BITS){1'b0}}, i_stage.span}
                            * {{(CW-FIELD_BITS){1'b0}}, i_stage.sat});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= i_stage.valid;
            if (i_stage.valid) begin
                r_c_hue_ok <= i_stage.hue_ok;
                r_c_sector <= i_stage.sector;
                r_c_chroma <= n_c_chroma;
                r_c_light  <= i_stage.light;
                r_c_t_fac  <= i_stage.t_fac;
            end
        end
    end

    // Second component and the lightness offset
    assign x_prod = {{FIELD_BITS{1'b0}}, r_c_chroma} * {{CW{1'b0}}, r_c_t_fac};

    always_comb begin
        n_stage        = r_stage;
        n_stage.valid  = r_c_valid;
        if (r_c_valid) begin
            n_stage.hue_ok = r_c_hue_ok;
            n_stage.sector = r_c_sector;
            n_stage.chroma = r_c_chroma;
            n_stage.x_val  = x_prod[FRAC_BITS +: CW];
            n_stage.m_val  = {r_c_light, {FRAC_BITS{1'b0}}} - (r_c_chroma >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ----- rtl/hsl2rgb_mix.sv -----
// Fourth and fifth pipeline stages: places c and x by hue sector, adds m,
// then quantizes each channel to a byte. Uses hsl2rgb_pkg.
module hsl2rgb_mix (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  hsl2rgb_pkg::t_mix_stage i_stage,
    output logic                    o_valid,
    output hsl2rgb_pkg::t_rgb_pixel o_rgb
);
    import hsl2rgb_pkg::*;

    logic [CW-1:0] sel_r;
    logic [CW-1:0] sel_g;
    logic [CW-1:0] sel_b;
    logic          r_s_valid;
    logic [VW-1:0] r_s_red;
    logic [VW-1:0] r_s_green;
    logic [VW-1:0] r_s_blue;
    logic          r_valid;
    t_rgb_pixel    r_rgb;

    // Route chroma and x to channels; out-of-range hue stays gray
    always_comb begin
        sel_r = '0;
        sel_g = '0;
        sel_b = '0;
        if (i_stage.hue_ok) begin
            case (i_stage.sector)
                SECT_RY: begin sel_r = i_stage.chroma; sel_g = i_stage.x_val; end
                SECT_YG: begin sel_r = i_stage.x_val;  sel_g = i_stage.chroma; end
                SECT_GC: begin sel_g = i_stage.chroma; sel_b = i_stage.x_val; end
                SECT_CB: begin sel_g = i_stage.x_val;  sel_b = i_stage.chroma; end
                SECT_BM: begin sel_r = i_stage.x_val;  sel_b = i_stage.chroma; end
                SECT_MR: begin sel_r = i_stage.chroma; sel_b = i_stage.x_val; end
                default: begin sel_r = '0; end
            endcase
        end
    end

    // Add the lightness offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else begin
            r_s_valid <= i_stage.valid;
            if (i_stage.valid) begin
                r_s_red   <= {1'b0, sel_r} + {1'b0, i_stage.m_val};
                r_s_green <= {1'b0, sel_g} + {1'b0, i_stage.m_val};
                r_s_blue  <= {1'b0, sel_b} + {1'b0, i_stage.m_val};
            end
        end
    end

    // Quantize to bytes and drive the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_s_valid;
            if (r_s_valid) begin
                r_rgb.red_byte   <= quantize(r_s_red);
                r_rgb.green_byte <= quantize(r_s_green);
                r_rgb.blue_byte  <= quantize(r_s_blue);
            end
        end
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;

endmodule

// ----- rtl/hsl_to_rgb24_pixel_unit.sv -----
// HSL to RGB24 pixel converter, five-stage pipeline.
//
// Usage:
//   Drive i_pixel (hue, saturation, lightness as Q0.16 fractions, 65536 = 1.0)
//   and raise start. An item is taken at every edge where start is high and
//   busy is low; busy never rises, so one pixel can be taken every cycle.
//   Each result appears on o_rgb for exactly one cycle with o_strobe high,
//   in input order. The receiver cannot hold results off and none is
//   needed: nothing waits inside. Throughput is one pixel per clock. Each
//   item passes in order through the stages prep, chroma multiply, x
//   multiply, channel add and quantize. Saturation and lightness above 1.0
//   are clamped; a hue of 1.0 or more gives gray. Reset (i_rst_n low,
//   synchronous) drops every item in flight and holds o_strobe low.
// Depends on hsl2rgb_pkg, hsl2rgb_prep, hsl2rgb_chroma, hsl2rgb_mix.
module hsl_to_rgb24_pixel_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  hsl2rgb_pkg::t_hsl_pixel i_pixel,
    output logic                    o_strobe,
    output hsl2rgb_pkg::t_rgb_pixel o_rgb
);
    import hsl2rgb_pkg::*;

    logic        in_take;
    t_prep_stage prep_stage;
    t_mix_stage  mix_stage;

    // Pipeline never stalls
    assign busy    = 1'b0;
    assign in_take = start && !busy;

    hsl2rgb_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_take),
        .i_pixel (i_pixel),
        .o_stage (prep_stage)
    );

    hsl2rgb_chroma u_chroma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (prep_stage),
        .o_stage (mix_stage)
    );

    hsl2rgb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (mix_stage),
        .o_valid (o_strobe),
        .o_rgb   (o_rgb)
    );

endmodule
